### sv/ppu_pkg.sv
// Package for the packed palette pixel unpacker: item structs, config
// layout, codes and small helper functions. No dependencies.
`default_nettype none

package ppu_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int MAX_DIMENSION = 16384;
    localparam int DIM_W         = $clog2(MAX_DIMENSION);
    localparam int CFG_DIM_W     = DIM_W + 1;
    localparam int FCOL_W        = DIM_W + 3;
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W     = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W     = OUT_PTR_W + 1;

    // item mode
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    // config register indexes
    localparam logic [2:0] CFG_INDEX_BITS = 3'd0;
    localparam logic [2:0] CFG_LSB_FIRST  = 3'd1;
    localparam logic [2:0] CFG_WIDTH      = 3'd2;
    localparam logic [2:0] CFG_HEIGHT     = 3'd3;
    localparam logic [2:0] CFG_ROW_SPAN   = 3'd4;
    localparam logic [2:0] CFG_OUT_BPP    = 3'd5;

    // index width codes
    localparam logic [1:0] BITS_1 = 2'd0;
    localparam logic [1:0] BITS_2 = 2'd1;
    localparam logic [1:0] BITS_4 = 2'd2;
    localparam logic [1:0] BITS_8 = 2'd3;

    // output pixel formats
    localparam logic [2:0] FMT_GRAY       = 3'd1;
    localparam logic [2:0] FMT_GRAY_ALPHA = 3'd2;
    localparam logic [2:0] FMT_RGB        = 3'd3;
    localparam logic [2:0] FMT_RGBA       = 3'd4;

    typedef struct packed {
        logic       mode;
        logic [7:0] palette_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
        logic [7:0] pal_alpha;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       sample_a;
        logic [7:0]       sample_b;
        logic [7:0]       sample_c;
        logic [7:0]       sample_d;
        logic [2:0]       sample_count;
        logic [DIM_W-1:0] pixel_column;
        logic [DIM_W-1:0] pixel_row;
        logic             last_of_run;
        logic             last_of_image;
    } out_item_t;

    typedef struct packed {
        logic [1:0]           index_bits_code;
        logic                 lsb_first;
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_DIM_W-1:0] row_span_bytes;
        logic [2:0]           out_bytes_per_pixel;
    } cfg_t;

    // palette write port: color packed as {red, green, blue, alpha}
    typedef struct packed {
        logic                  en;
        logic [PAL_ADDR_W-1:0] addr;
        logic [31:0]           data;
    } pal_wr_t;

    // per-pixel info that travels alongside the palette read
    typedef struct packed {
        logic             in_range;
        logic [2:0]       fmt;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             last_run;
        logic             last_image;
    } issue_t;

    function automatic logic [7:0] idx_mask(input logic [1:0] code);
        logic [7:0] m;
        case (code)
            BITS_1:  m = 8'h01;
            BITS_2:  m = 8'h03;
            BITS_4:  m = 8'h0f;
            default: m = 8'hff;
        endcase
        return m;
    endfunction

    // bytes per row actually consumed: max(span, needed), capped
    function automatic logic [CFG_DIM_W-1:0] row_span(input cfg_t c);
        logic [CFG_DIM_W+3:0] needed;
        logic [CFG_DIM_W+3:0] span;
        needed = (({4'd0, c.image_width} << c.index_bits_code) + (CFG_DIM_W+4)'(7)) >> 3;
        span   = ({4'd0, c.row_span_bytes} > needed) ? {4'd0, c.row_span_bytes} : needed;
        if (span > (CFG_DIM_W+4)'(MAX_DIMENSION))
            span = (CFG_DIM_W+4)'(MAX_DIMENSION);
        return span[CFG_DIM_W-1:0];
    endfunction

    function automatic logic [2:0] clamp_fmt(input logic [2:0] f);
        logic [2:0] r;
        if (f == 3'd0)
            r = FMT_GRAY;
        else if (f > FMT_RGBA)
            r = FMT_RGBA;
        else
            r = f;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ppu_palette_ram.sv
// Palette memory: one write port, one registered read port.
// Depends on ppu_pkg. Read of an address written the same cycle returns old data.
`default_nettype none

module ppu_palette_ram (
    input  wire logic                          clk,
    input  wire ppu_pkg::pal_wr_t              wr,
    input  wire logic                          rd_en,
    input  wire logic [ppu_pkg::PAL_ADDR_W-1:0] rd_addr,
    output logic [31:0]                        rd_data
);
    import ppu_pkg::*;

    logic [31:0] mem [PALETTE_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/ppu_sequencer.sv
// Item sequencer: palette writes, row/image counters, and one palette
// read per pixel. Depends on ppu_pkg.
`default_nettype none

module ppu_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ppu_pkg::cfg_t                  cfg,
    input  wire logic                           feed_valid,
    output logic                                feed_stall,
    input  wire ppu_pkg::in_item_t              feed_item,
    input  wire logic                           can_issue,
    output ppu_pkg::pal_wr_t                    pal_wr,
    output logic                                rd_en,
    output logic [ppu_pkg::PAL_ADDR_W-1:0]      rd_addr,
    output ppu_pkg::issue_t                     issue
);
    import ppu_pkg::*;

    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    logic                 busy_reg;
    logic [2:0]           k_reg;
    logic [3:0]           cnt_reg;
    logic [DIM_W-1:0]     rbc_reg;
    logic [DIM_W-1:0]     rc_reg;
    logic [7:0]           byte_reg;
    logic [DIM_W-1:0]     first_col_reg;
    logic [DIM_W-1:0]     row_reg;

    logic                 dims_ok;
    logic [CFG_DIM_W-1:0] span;
    logic                 issue_fire;
    logic                 last_pix;
    logic                 ready;
    logic                 accept;
    logic                 data_accept;

    logic                 row_wrap_start;
    logic [DIM_W-1:0]     rbc0;
    logic [CFG_DIM_W-1:0] rc0;
    logic [DIM_W-1:0]     rc1;
    logic [FCOL_W-1:0]    first_col;
    logic [3:0]           per_byte;
    logic [FCOL_W-1:0]    remain;
    logic [3:0]           n_pix;
    logic [CFG_DIM_W-1:0] rbc1;
    logic                 end_row;
    logic [CFG_DIM_W-1:0] rc2;
    logic [DIM_W-1:0]     rbc_next;
    logic [DIM_W-1:0]     rc_next;

    logic [3:0]           kk;
    logic [3:0]           sh;
    logic [7:0]           idx;
    logic [DIM_W-1:0]     col;

    assign dims_ok = (cfg.image_width != '0)
                  && (cfg.image_width <= CFG_DIM_W'(MAX_DIMENSION))
                  && (cfg.image_height != '0)
                  && (cfg.image_height <= CFG_DIM_W'(MAX_DIMENSION));
    assign span = row_span(cfg);

    assign issue_fire  = busy_reg && can_issue;
    assign last_pix    = ({1'b0, k_reg} == (cnt_reg - 4'd1));
    assign ready       = !busy_reg || (issue_fire && last_pix);
    assign feed_stall  = !ready;
    assign accept      = feed_valid && ready;
    assign data_accept = accept && (feed_item.mode == MODE_DATA) && dims_ok;

    // palette write goes straight to memory on accept
    always_comb
    begin
        pal_wr.en   = accept && (feed_item.mode == MODE_PALETTE)
                   && ({1'b0, feed_item.palette_index} < PAL_LIMIT);
        pal_wr.addr = feed_item.palette_index[PAL_ADDR_W-1:0];
        pal_wr.data = {feed_item.pal_red, feed_item.pal_green,
                       feed_item.pal_blue, feed_item.pal_alpha};
    end

    // row bookkeeping for a data byte
    always_comb
    begin
        row_wrap_start = ({1'b0, rbc_reg} >= span);
        rbc0     = row_wrap_start ? '0 : rbc_reg;
        rc0      = {1'b0, rc_reg} + CFG_DIM_W'(row_wrap_start);
        rc1      = (rc0 >= cfg.image_height) ? '0 : rc0[DIM_W-1:0];
        first_col = FCOL_W'(rbc0) << (2'd3 - cfg.index_bits_code);
        per_byte = 4'd8 >> cfg.index_bits_code;
        remain   = FCOL_W'(cfg.image_width) - first_col;
        if (first_col >= FCOL_W'(cfg.image_width))
            n_pix = 4'd0;
        else if (remain < FCOL_W'(per_byte))
            n_pix = remain[3:0];
        else
            n_pix = per_byte;
        rbc1     = {1'b0, rbc0} + CFG_DIM_W'(1);
        end_row  = (rbc1 >= span);
        rc2      = {1'b0, rc1} + CFG_DIM_W'(1);
        if (end_row)
        begin
            rbc_next = '0;
            rc_next  = (rc2 >= cfg.image_height) ? '0 : rc2[DIM_W-1:0];
        end
        else
        begin
            rbc_next = rbc1[DIM_W-1:0];
            rc_next  = rc1;
        end
    end

    // index extraction and pixel info
    always_comb
    begin
        kk = {1'b0, k_reg};
        if (cfg.lsb_first)
            sh = kk << cfg.index_bits_code;
        else
            sh = 4'd8 - ((kk + 4'd1) << cfg.index_bits_code);
        idx = (byte_reg >> sh[2:0]) & idx_mask(cfg.index_bits_code);
        col = first_col_reg + DIM_W'(k_reg);

        rd_en            = issue_fire;
        rd_addr          = idx[PAL_ADDR_W-1:0];
        issue.in_range   = ({1'b0, idx} < PAL_LIMIT);
        issue.fmt        = clamp_fmt(cfg.out_bytes_per_pixel);
        issue.col        = col;
        issue.row        = row_reg;
        issue.last_run   = last_pix;
        issue.last_image = ({1'b0, col} == (cfg.image_width - CFG_DIM_W'(1)))
                        && ({1'b0, row_reg} == (cfg.image_height - CFG_DIM_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            cnt_reg  <= '0;
            rbc_reg  <= '0;
            rc_reg   <= '0;
        end
        else
        begin
            // a new byte with pixels takes over from the one just finished
            if (data_accept && (n_pix != 4'd0))
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
                cnt_reg  <= n_pix;
            end
            else if (issue_fire)
            begin
                k_reg <= k_reg + 3'd1;
                if (last_pix)
                    busy_reg <= 1'b0;
            end
            if (data_accept)
            begin
                rbc_reg <= rbc_next;
                rc_reg  <= rc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_accept)
        begin
            byte_reg      <= feed_item.data_byte;
            first_col_reg <= first_col[DIM_W-1:0];
            row_reg       <= rc1;
        end
    end

    a_pix_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 4'd0) && (cnt_reg <= 4'd8) && ({1'b0, k_reg} < cnt_reg))
        else $error("pixel counter out of range");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && !issue.last_run) |=> busy_reg)
        else $error("byte ended before its last pixel");

endmodule

`default_nettype wire

### sv/ppu_out_stage.sv
// Output stage: pairs palette read data with pixel info, formats the
// samples and queues results. Depends on ppu_pkg.
`default_nettype none

module ppu_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              issue_valid,
    input  wire ppu_pkg::issue_t   issue,
    input  wire logic [31:0]       rd_data,
    output logic                   can_issue,
    output logic                   pix_valid,
    input  wire logic              pix_stall,
    output ppu_pkg::out_item_t     pix_item
);
    import ppu_pkg::*;

    logic                 meta_valid_reg;
    issue_t               meta_reg;
    out_item_t            fifo_mem [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;

    out_item_t            fmt_item;
    logic [31:0]          color;
    logic                 push;
    logic                 pop;

    // reserve a slot for the read in flight
    assign can_issue = ({1'b0, count_reg} + (OUT_CNT_W+1)'(meta_valid_reg))
                     < (OUT_CNT_W+1)'(OUT_FIFO_DEPTH);
    assign push      = meta_valid_reg;
    assign pop       = (count_reg != '0) && !pix_stall;
    assign pix_valid = (count_reg != '0);
    assign pix_item  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        color = meta_reg.in_range ? rd_data : 32'd0;
        fmt_item.sample_a = 8'd0;
        fmt_item.sample_b = 8'd0;
        fmt_item.sample_c = 8'd0;
        fmt_item.sample_d = 8'd0;
        case (meta_reg.fmt)
            FMT_GRAY:
            begin
                fmt_item.sample_a = color[23:16];
            end
            FMT_GRAY_ALPHA:
            begin
                fmt_item.sample_a = color[23:16];
                fmt_item.sample_b = color[7:0];
            end
            FMT_RGB:
            begin
                fmt_item.sample_a = color[31:24];
                fmt_item.sample_b = color[23:16];
                fmt_item.sample_c = color[15:8];
            end
            default:
            begin
                fmt_item.sample_a = color[31:24];
                fmt_item.sample_b = color[23:16];
                fmt_item.sample_c = color[15:8];
                fmt_item.sample_d = color[7:0];
            end
        endcase
        fmt_item.sample_count  = meta_reg.fmt;
        fmt_item.pixel_column  = meta_reg.col;
        fmt_item.pixel_row     = meta_reg.row;
        fmt_item.last_of_run   = meta_reg.last_run;
        fmt_item.last_of_image = meta_reg.last_image;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            meta_valid_reg <= issue_valid;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            count_reg <= count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_valid)
            meta_reg <= issue;
        if (push)
            fifo_mem[wr_ptr_reg] <= fmt_item;
    end

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUT_CNT_W'(OUT_FIFO_DEPTH))
        else $error("output queue overflow");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        issue_valid |=> meta_valid_reg)
        else $error("palette read lost its pixel info");

endmodule

`default_nettype wire

### sv/packed_palette_pixel_unpacker_unit.sv
// Top level of the packed palette pixel unpacker: config registers and
// the sequencer, palette memory and output stage. Depends on ppu_pkg.
//
// Usage:
//   feed channel (feed_valid / feed_stall / feed_item): mode 0 items write a
//   palette entry, mode 1 items carry one packed image byte. pix channel
//   (pix_valid / pix_stall / pix_item): one item per pixel, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes a
//   configuration register; always ready. Write only while idle.
// Path: the first pixel of a byte is offered once the byte is taken and
//   registered, then read from the palette, then written to the queue.
// Throughput: one pixel per cycle while the output queue has room, set by
//   the single palette read port; a byte gives at most 8, 4, 2 or 1 pixels
//   at 1, 2, 4 or 8 bits per index. Palette writes and bytes without pixels issue no read.
// Stall: a 4-entry output queue absorbs results; palette reads stop when it
//   fills, and feed_stall rises while a byte still has pixels to issue.
// Reset: counters cleared, registers to defaults (8-bit index, MSB first,
//   1x1 image, span 1, RGBA). Palette contents are undefined until written.
`default_nettype none

module packed_palette_pixel_unpacker_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                feed_valid,
    output logic                     feed_stall,
    input  wire ppu_pkg::in_item_t   feed_item,
    output logic                     pix_valid,
    input  wire logic                pix_stall,
    output ppu_pkg::out_item_t       pix_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [ppu_pkg::CFG_DIM_W-1:0] cfg_data
);
    import ppu_pkg::*;

    cfg_t        cfg_reg;
    pal_wr_t     pal_wr;
    logic        rd_en;
    logic [PAL_ADDR_W-1:0] rd_addr;
    logic [31:0] rd_data;
    issue_t      issue;
    logic        can_issue;

    assign cfg_ready = 1'b1;

    // config registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_bits_code     <= BITS_8;
            cfg_reg.lsb_first           <= 1'b0;
            cfg_reg.image_width         <= CFG_DIM_W'(1);
            cfg_reg.image_height        <= CFG_DIM_W'(1);
            cfg_reg.row_span_bytes      <= CFG_DIM_W'(1);
            cfg_reg.out_bytes_per_pixel <= FMT_RGBA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INDEX_BITS: cfg_reg.index_bits_code     <= cfg_data[1:0];
                CFG_LSB_FIRST:  cfg_reg.lsb_first           <= cfg_data[0];
                CFG_WIDTH:      cfg_reg.image_width         <= cfg_data;
                CFG_HEIGHT:     cfg_reg.image_height        <= cfg_data;
                CFG_ROW_SPAN:   cfg_reg.row_span_bytes      <= cfg_data;
                CFG_OUT_BPP:    cfg_reg.out_bytes_per_pixel <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // byte intake, counters and one palette read per pixel
    ppu_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .feed_valid (feed_valid),
        .feed_stall (feed_stall),
        .feed_item  (feed_item),
        .can_issue  (can_issue),
        .pal_wr     (pal_wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .issue      (issue)
    );

    // palette: a write and a read of the same entry in one cycle returns
    // the old color, which matches item order (the read is the older item)
    ppu_palette_ram u_pal (
        .clk     (clk),
        .wr      (pal_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // formatting and result queue
    ppu_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (rd_en),
        .issue       (issue),
        .rd_data     (rd_data),
        .can_issue   (can_issue),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix_item    (pix_item)
    );

endmodule

`default_nettype wire

### tb/packed_palette_pixel_unpacker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for packed_palette_pixel_unpacker_unit. Predicts every
// pixel from palette writes and packed bytes. Depends on ppu_pkg and the unit.

module packed_palette_pixel_unpacker_unit_tb;

    import ppu_pkg::*;

    localparam int RANDOM_ITEMS   = 350;  // counted items in the random part
    localparam int SETTLE_CYCLES  = 8;    // latency pause before a register write
    localparam int DRAIN_CYCLES   = 16;   // quiet time after the last pixel
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no handshake at all

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 feed_valid = 1'b0;
    logic                 feed_stall;
    in_item_t             feed_item = '0;
    logic                 pix_valid;
    logic                 pix_stall = 1'b0;
    out_item_t            pix_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [CFG_DIM_W-1:0] cfg_data = '0;

    packed_palette_pixel_unpacker_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (feed_valid),
        .feed_stall (feed_stall),
        .feed_item  (feed_item),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: palette copy, register copy and position counters.
    // Only touched at rising edges (item taken) or by register writes,
    // which happen while the unit is idle.
    // ------------------------------------------------------------------
    logic [31:0] palette_model [PALETTE_DEPTH];  // {red, green, blue, alpha}
    int m_bits_code = BITS_8;
    int m_lsb       = 0;
    int m_width     = 1;
    int m_height    = 1;
    int m_span      = 1;
    int m_fmt       = FMT_RGBA;
    int byte_pos    = 0;   // byte within the current row
    int row_pos     = 0;   // current row

    out_item_t expected_pixels [$];
    in_item_t  queued_feed_items [$];

    // Stimulus-side bookkeeping
    int   items_queued   = 0;
    int   items_accepted = 0;
    bit   feed_taken     = 1'b0;
    bit   hold_feed      = 1'b0;
    bit   idle_enable    = 1'b1;
    int   feed_gap       = 0;
    int   stall_left     = 0;
    int   error_count    = 0;
    int   pixels_checked = 0;
    int   image_ends     = 0;
    int   settings_used  = 0;
    int   idle_cycles    = 0;

    // Which palette entries have been loaded, as seen by the generator.
    // Data bytes only ever point at loaded entries.
    bit   entry_loaded [PALETTE_DEPTH];
    int   loaded_entries [$];
    logic [1:0] gen_bits_code = BITS_8;
    bit   gen_dims_ok = 1'b1;

    // Works out the pixels one taken item causes and advances the counters.
    task automatic unpack_to_pixels(input in_item_t it);
        int bits, per_byte, needed, span, first_col, n_pix, col, shift, idx, k;
        logic [2:0]  fmt;
        logic [31:0] color;
        out_item_t   px;
        if (it.mode == MODE_PALETTE) begin
            palette_model[it.palette_index] =
                {it.pal_red, it.pal_green, it.pal_blue, it.pal_alpha};
            return;
        end
        // bad dimensions: nothing out, counters untouched
        if (m_width == 0 || m_width > MAX_DIMENSION ||
            m_height == 0 || m_height > MAX_DIMENSION)
            return;
        bits     = 1 << m_bits_code;
        per_byte = 8 / bits;
        needed   = (m_width * bits + 7) / 8;
        // a span below the needed byte count is raised, then capped
        span     = (m_span > needed) ? m_span : needed;
        if (span > MAX_DIMENSION)
            span = MAX_DIMENSION;
        if (m_fmt == 0)
            fmt = FMT_GRAY;
        else if (m_fmt > FMT_RGBA)
            fmt = FMT_RGBA;
        else
            fmt = 3'(m_fmt);
        // counters left past new limits by a register change
        if (byte_pos >= span) begin
            byte_pos = 0;
            row_pos++;
        end
        if (row_pos >= m_height)
            row_pos = 0;
        first_col = byte_pos * per_byte;
        if (first_col >= m_width)
            n_pix = 0;       // padding, or pixels past the row width
        else if (m_width - first_col < per_byte)
            n_pix = m_width - first_col;
        else
            n_pix = per_byte;
        for (k = 0; k < n_pix; k++) begin
            col   = first_col + k;
            shift = m_lsb ? k * bits : 8 - (k + 1) * bits;
            idx   = (it.data_byte >> shift) & ((1 << bits) - 1);
            color = palette_model[idx];
            px    = '0;
            case (fmt)
                FMT_GRAY: px.sample_a = color[23:16];
                FMT_GRAY_ALPHA: begin
                    px.sample_a = color[23:16];
                    px.sample_b = color[7:0];
                end
                FMT_RGB: begin
                    px.sample_a = color[31:24];
                    px.sample_b = color[23:16];
                    px.sample_c = color[15:8];
                end
                default: begin
                    px.sample_a = color[31:24];
                    px.sample_b = color[23:16];
                    px.sample_c = color[15:8];
                    px.sample_d = color[7:0];
                end
            endcase
            px.sample_count  = fmt;
            px.pixel_column  = DIM_W'(col);
            px.pixel_row     = DIM_W'(row_pos);
            px.last_of_run   = (k == n_pix - 1);
            px.last_of_image = (col == m_width - 1) && (row_pos == m_height - 1);
            expected_pixels.push_back(px);
        end
        byte_pos++;
        if (byte_pos >= span) begin
            byte_pos = 0;
            row_pos++;
            if (row_pos >= m_height)
                row_pos = 0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Feed side. The rising edge records a taken item and runs the
    // predictor; the falling edge decides what to offer next.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : feed_accept
        if (rst_n && feed_valid && !feed_stall) begin
            unpack_to_pixels(feed_item);
            items_accepted++;
            feed_taken = 1'b1;
        end
    end

    always @(negedge clk) begin : feed_driver
        // a stalled item stays put; otherwise pick the next move
        if (rst_n && !(feed_valid && !feed_taken)) begin
            feed_taken = 1'b0;
            if (feed_gap > 0) begin
                feed_gap--;
                feed_valid <= 1'b0;
            end else if (hold_feed || queued_feed_items.size() == 0) begin
                feed_valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                feed_gap = $urandom_range(0, 5);   // start a random idle burst
                feed_valid <= 1'b0;
            end else begin
                feed_item  <= queued_feed_items.pop_front();
                feed_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel side: random stall bursts, compare against the oldest
    // expectation on every taken pixel.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : pix_stall_driver
        if (stall_left > 0) begin
            stall_left--;
            pix_stall <= 1'b1;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            pix_stall <= 1'b1;
        end else begin
            pix_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : pix_monitor
        out_item_t want;
        if (rst_n && pix_valid && !pix_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel with nothing expected: column %0d row %0d",
                       pix_item.pixel_column, pix_item.pixel_row);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("sample_a", want.sample_a, pix_item.sample_a);
                check_field("sample_b", want.sample_b, pix_item.sample_b);
                check_field("sample_c", want.sample_c, pix_item.sample_c);
                check_field("sample_d", want.sample_d, pix_item.sample_d);
                check_field("sample_count", want.sample_count, pix_item.sample_count);
                check_field("pixel_column", want.pixel_column, pix_item.pixel_column);
                check_field("pixel_row", want.pixel_row, pix_item.pixel_row);
                check_field("last_of_run", want.last_of_run, pix_item.last_of_run);
                check_field("last_of_image", want.last_of_image, pix_item.last_of_image);
                pixels_checked++;
                if (want.last_of_image)
                    image_ends++;
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (feed_valid && !feed_stall) || (pix_valid && !pix_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d pixels still expected",
                   WATCHDOG_LIMIT, expected_pixels.size());
            $display("packed_palette_pixel_unpacker_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_palette_write(input int index, input logic [31:0] rgba);
        in_item_t it;
        it = '0;
        it.mode          = MODE_PALETTE;
        it.palette_index = 8'(index);
        {it.pal_red, it.pal_green, it.pal_blue, it.pal_alpha} = rgba;
        it.data_byte     = 8'($urandom);   // ignored in a palette write
        queued_feed_items.push_back(it);
        items_queued++;
        if (!entry_loaded[index]) begin
            entry_loaded[index] = 1'b1;
            loaded_entries.push_back(index);
        end
    endtask

    task automatic queue_data_byte(input logic [7:0] value);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});  // noise in the unused fields
        it.mode      = MODE_DATA;
        it.data_byte = value;
        queued_feed_items.push_back(it);
        items_queued++;
    endtask

    // Indices below 16 are loaded up front, so only 8-bit indices need a pick
    // from the loaded list.
    function automatic logic [7:0] pick_data_byte();
        logic [7:0] value;
        if (gen_bits_code == BITS_8)
            value = 8'(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]);
        else
            value = 8'($urandom_range(0, 255));
        return value;
    endfunction

    task automatic write_reg(input logic [2:0] index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DIM_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_INDEX_BITS: m_bits_code = value & 3;
            CFG_LSB_FIRST:  m_lsb       = value & 1;
            CFG_WIDTH:      m_width     = value & 16'h7fff;
            CFG_HEIGHT:     m_height    = value & 16'h7fff;
            CFG_ROW_SPAN:   m_span      = value & 16'h7fff;
            CFG_OUT_BPP:    m_fmt       = value & 7;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Waits until every item is taken and every pixel seen, lets the
    // pipeline settle, then writes all six registers.
    task automatic reconfigure(input int bits_code, input int lsb, input int width,
                               input int height, input int span, input int fmt);
        while (!(items_accepted == items_queued && expected_pixels.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_INDEX_BITS, bits_code);
        write_reg(CFG_LSB_FIRST, lsb);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
        write_reg(CFG_ROW_SPAN, span);
        write_reg(CFG_OUT_BPP, fmt);
        cfg_valid <= 1'b0;
        gen_bits_code = 2'(bits_code);
        gen_dims_ok   = width >= 1 && width <= MAX_DIMENSION &&
                        height >= 1 && height <= MAX_DIMENSION;
        settings_used++;
    endtask

    function automatic int pick_dimension(input int usual_max);
        int value;
        case ($urandom_range(0, 19))
            0:       value = 0;                                  // bad: zero
            1:       value = $urandom_range(MAX_DIMENSION + 1, 32767); // bad: too big
            2:       value = MAX_DIMENSION;
            default: value = $urandom_range(1, usual_max);
        endcase
        return value;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int counted, phase, n, i, half;
        int r_bits, r_lsb, r_width, r_height, r_span, r_fmt;
        counted = 0;
        phase   = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: load entries 0..15 and 255 (extremes in 0 and 15), then a
        // couple of bytes under the reset settings (8-bit, 1x1, RGBA).
        queue_palette_write(0, 32'h0000_0000);
        for (i = 1; i < 15; i++)
            queue_palette_write(i, $urandom);
        queue_palette_write(15, 32'hffff_ffff);
        queue_palette_write(255, $urandom);
        queue_data_byte(8'h00);
        queue_data_byte(8'hff);

        // 1-bit MSB first, width 10: span 1 is raised to the 2 bytes needed;
        // format 0 reads as gray. Second row starts with the third byte.
        reconfigure(BITS_1, 0, 10, 2, 1, 0);
        queue_data_byte(8'ha5);
        queue_data_byte(8'h5a);
        queue_data_byte(8'hff);

        // Zero width, then an oversized height: bytes give nothing and leave
        // the counters where they were.
        reconfigure(BITS_2, 0, 0, 2, 1, FMT_RGB);
        queue_data_byte(8'h3c);
        reconfigure(BITS_2, 0, 3, 32767, 1, FMT_RGB);
        queue_data_byte(8'hc3);

        // 4-bit LSB first, width 3 span 3, height 1, format 7 (reads as RGBA).
        // The leftover row count wraps, the middle byte is past the width
        // and the last one starts the new row.
        reconfigure(BITS_4, 1, 3, 1, 3, 7);
        queue_data_byte(8'h12);
        queue_data_byte(8'h34);
        queue_data_byte(8'h56);

        // Random part: one register setting per phase, a mix of palette
        // writes and data bytes under it.
        while (counted < RANDOM_ITEMS) begin
            case (phase)
                0: begin   // width, height and span at their largest
                    r_bits = BITS_8; r_lsb = 1; r_width = MAX_DIMENSION;
                    r_height = MAX_DIMENSION; r_span = 32767; r_fmt = FMT_GRAY_ALPHA;
                end
                1: begin   // every pixel is a whole image
                    r_bits = BITS_1; r_lsb = 0; r_width = 1;
                    r_height = 1; r_span = 1; r_fmt = FMT_RGB;
                end
                2: begin   // widest field value, far past the limit
                    r_bits = BITS_2; r_lsb = 1; r_width = 32767;
                    r_height = 1; r_span = 1; r_fmt = 5;
                end
                default: begin
                    r_bits   = $urandom_range(0, 3);
                    r_lsb    = $urandom_range(0, 1);
                    r_width  = pick_dimension(24);
                    r_height = pick_dimension(4);
                    case ($urandom_range(0, 9))
                        0:       r_span = 32767;
                        1:       r_span = MAX_DIMENSION;
                        default: r_span = $urandom_range(1, 8);
                    endcase
                    r_fmt    = $urandom_range(0, 7);
                end
            endcase
            reconfigure(r_bits, r_lsb, r_width, r_height, r_span, r_fmt);
            // no idling at all near the end, and now and then a clean phase
            idle_enable = (counted < RANDOM_ITEMS - 60) && ($urandom_range(0, 3) != 0);

            n = gen_dims_ok ? $urandom_range(8, 40) : $urandom_range(2, 4);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_palette_write($urandom_range(0, 255), $urandom);
                    counted++;
                end else begin
                    queue_data_byte(pick_data_byte());
                    if (gen_dims_ok)
                        counted++;
                end
            end

            // Every third phase the sender stops midway until the unit has
            // delivered everything it owes, then resumes.
            if (phase % 3 == 1) begin
                half = n / 2;
                while (queued_feed_items.size() > half)
                    @(negedge clk);
                hold_feed = 1'b1;
                @(negedge clk);
                while (feed_valid || expected_pixels.size() != 0)
                    @(negedge clk);
                hold_feed = 1'b0;
            end
            phase++;
        end

        // Drain, then give the unit time to show any stray pixel.
        while (!(items_accepted == items_queued && expected_pixels.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            error_count++;
        end
        $display("Run covered %0d items under %0d register settings, %0d random phases;",
                 items_accepted, settings_used + 1, phase);
        $display("%0d pixels compared, %0d of them closing an image.",
                 pixels_checked, image_ends);
        if (error_count == 0)
            $display("packed_palette_pixel_unpacker_unit_tb passed");
        else
            $display("packed_palette_pixel_unpacker_unit_tb failed");
        $finish;
    end

endmodule

### sim.f
sv/ppu_pkg.sv
sv/ppu_palette_ram.sv
sv/ppu_sequencer.sv
sv/ppu_out_stage.sv
sv/packed_palette_pixel_unpacker_unit.sv
tb/packed_palette_pixel_unpacker_unit_tb.sv
